// File: hdl/lrupfr_pkg.sv
package lrupfr_pkg;

  localparam int NUM_FRAMES = 8;
  localparam int PAGE_BITS  = 8;
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int RANK_W     = $clog2(NUM_FRAMES);
  localparam int CFG_W      = 4;
  localparam int FAULT_W    = 16;

  localparam logic [7:0]         PAGE_MASK   = 8'((64'd1 << PAGE_BITS) - 64'd1);
  localparam logic [RANK_W-1:0]  RANK_OLDEST = RANK_W'(NUM_FRAMES - 1);
  localparam logic [FAULT_W-1:0] FAULT_MAX   = '1;
  localparam logic [CFG_W-1:0]   CFG_RESET   = CFG_W'(8);
  localparam logic [CFG_W-1:0]   CFG_LIMIT   = CFG_W'(NUM_FRAMES);

  typedef struct packed {
    logic [7:0] page_number;
    logic       restart;
  } lrupfr_req_t;

  typedef struct packed {
    logic               hit;
    logic [2:0]         frame_index;
    logic               evicted_valid;
    logic [7:0]         evicted_page;
    logic [FAULT_W-1:0] fault_count;
  } lrupfr_res_t;

endpackage

// File: hdl/lru_page_frame_replacer.sv
// LRU page frame replacer.
// Request channel: in_valid / in_stall / in_req carry one page reference
// (page_number, restart). Result channel: out_valid / out_stall / out_res carry
// hit, frame_index, evicted_valid, evicted_page and fault_count, one result per
// request, in request order.
// cfg_write / cfg_data set frames_in_use (0 acts as 1, above 8 acts as 8);
// write it only while no request is in flight.
// A request is held in the request register; its result is then written to the result register.
// Throughput: one request per clock while the receiver does not hold out_stall.
// The lookup, victim choice and rank update for a request settle combinationally
// between the request register and the result register, so the next request sees the updated frames directly.
// Reset (rst, synchronous): all frames empty, ranks and fault count zero,
// frames_in_use back to 8; frame contents are not cleared.
// When the receiver holds out_stall, the result register keeps its value, the
// request register keeps the next request, and in_stall rises only once both
// are full.
module lru_page_frame_replacer
  import lrupfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  lrupfr_req_t      in_req,
  output logic             out_valid,
  input  logic             out_stall,
  output lrupfr_res_t      out_res
);

  logic [CFG_W-1:0]   frames_in_use;
  logic               req_valid;
  lrupfr_req_t        req;

  logic [7:0]         frame_page  [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] frame_valid;
  logic [RANK_W-1:0]  recency_rank [NUM_FRAMES];
  logic [FAULT_W-1:0] fault_total;

  logic                  do_step;
  logic [CFG_W-1:0]      n_act;
  logic [NUM_FRAMES-1:0] act;
  logic [NUM_FRAMES-1:0] v_eff;
  logic [RANK_W-1:0]     r_eff [NUM_FRAMES];
  logic [FAULT_W-1:0]    fault_eff;
  logic [7:0]            page;
  logic [NUM_FRAMES-1:0] match;
  logic [NUM_FRAMES-1:0] empty;
  logic [NUM_FRAMES-1:0] is_max;
  logic                  hit_any;
  logic                  emp_any;
  logic [FRAME_W-1:0]    hit_idx;
  logic [FRAME_W-1:0]    emp_idx;
  logic [FRAME_W-1:0]    vic_idx;
  logic [FRAME_W-1:0]    f_sel;
  logic [RANK_W-1:0]     old_rank;
  logic [NUM_FRAMES-1:0] frame_valid_next;
  logic [RANK_W-1:0]     recency_rank_next [NUM_FRAMES];
  logic [FAULT_W-1:0]    fault_total_next;
  lrupfr_res_t           res_next;

  assign do_step  = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !do_step;

  always_comb begin
    if (frames_in_use == '0) begin
      n_act = CFG_W'(1);
    end else if (frames_in_use > CFG_LIMIT) begin
      n_act = CFG_LIMIT;
    end else begin
      n_act = frames_in_use;
    end

    page      = req.page_number & PAGE_MASK;
    fault_eff = req.restart ? '0 : fault_total;

    for (int k = 0; k < NUM_FRAMES; k++) begin
      act[k]   = (k < int'(n_act));
      v_eff[k] = frame_valid[k] && !req.restart;
      r_eff[k] = req.restart ? '0 : recency_rank[k];
      match[k] = act[k] && v_eff[k] && (frame_page[k] == page);
      empty[k] = act[k] && !v_eff[k];
    end

    // first maximum rank among active frames
    for (int k = 0; k < NUM_FRAMES; k++) begin
      is_max[k] = act[k];
      for (int j = 0; j < NUM_FRAMES; j++) begin
        if (act[j] && j < k && r_eff[j] >= r_eff[k]) begin
          is_max[k] = 1'b0;
        end
        if (act[j] && j > k && r_eff[j] > r_eff[k]) begin
          is_max[k] = 1'b0;
        end
      end
    end

    hit_any = |match;
    emp_any = |empty;
    hit_idx = '0;
    emp_idx = '0;
    vic_idx = '0;
    for (int k = NUM_FRAMES - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_idx = FRAME_W'(k);
      end
      if (empty[k]) begin
        emp_idx = FRAME_W'(k);
      end
      if (is_max[k]) begin
        vic_idx = FRAME_W'(k);
      end
    end

    if (hit_any) begin
      f_sel = hit_idx;
    end else if (emp_any) begin
      f_sel = emp_idx;
    end else begin
      f_sel = vic_idx;
    end
    old_rank = r_eff[f_sel];

    frame_valid_next = v_eff;
    for (int k = 0; k < NUM_FRAMES; k++) begin
      recency_rank_next[k] = r_eff[k];
    end

    if (!hit_any && emp_any) begin
      for (int k = 0; k < NUM_FRAMES; k++) begin
        if (v_eff[k] && r_eff[k] != RANK_OLDEST) begin
          recency_rank_next[k] = r_eff[k] + RANK_W'(1);
        end
      end
      frame_valid_next[f_sel] = 1'b1;
    end else begin
      // move f_sel to the front, younger valid frames age by one
      for (int k = 0; k < NUM_FRAMES; k++) begin
        if (FRAME_W'(k) != f_sel && v_eff[k] && r_eff[k] < old_rank) begin
          recency_rank_next[k] = r_eff[k] + RANK_W'(1);
        end
      end
    end
    recency_rank_next[f_sel] = '0;

    if (hit_any || fault_eff == FAULT_MAX) begin
      fault_total_next = fault_eff;
    end else begin
      fault_total_next = fault_eff + FAULT_W'(1);
    end

    res_next.hit           = hit_any;
    res_next.frame_index   = 3'(f_sel);
    res_next.evicted_valid = !hit_any && !emp_any;
    res_next.evicted_page  = (!hit_any && !emp_any) ? frame_page[f_sel] : 8'd0;
    res_next.fault_count   = fault_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_RESET;
      req_valid     <= 1'b0;
      out_valid     <= 1'b0;
      frame_valid   <= '0;
      fault_total   <= '0;
      for (int k = 0; k < NUM_FRAMES; k++) begin
        recency_rank[k] <= '0;
      end
    end else begin
      if (cfg_write) begin
        frames_in_use <= cfg_data;
      end
      if (in_valid && !in_stall) begin
        req_valid <= 1'b1;
      end else if (do_step) begin
        req_valid <= 1'b0;
      end
      if (do_step) begin
        out_valid   <= 1'b1;
        frame_valid <= frame_valid_next;
        fault_total <= fault_total_next;
        for (int k = 0; k < NUM_FRAMES; k++) begin
          recency_rank[k] <= recency_rank_next[k];
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req <= in_req;
    end
    if (do_step) begin
      out_res <= res_next;
      if (!hit_any) begin
        frame_page[f_sel] <= page;
      end
    end
  end

  a_step_gives_result: assert property (@(posedge clk) disable iff (rst)
    do_step |=> out_valid)
    else $error("processed request did not produce a result");

  a_hit_keeps_faults: assert property (@(posedge clk) disable iff (rst)
    do_step && hit_any |=> fault_total == $past(fault_total))
    else $error("fault count moved on a hit");

  a_fill_no_evict: assert property (@(posedge clk) disable iff (rst)
    do_step && !hit_any && emp_any |=> !out_res.evicted_valid)
    else $error("eviction reported while an empty frame was filled");

  a_step_leaves_valid: assert property (@(posedge clk) disable iff (rst)
    do_step |=> frame_valid != '0)
    else $error("no valid frame after a request");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    do_step && hit_any |=> out_res.hit && !out_res.evicted_valid)
    else $error("hit result reports an eviction");

endmodule

// File: verif/lru_page_frame_replacer_test.sv
module lru_page_frame_replacer_test
  import lrupfr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_CYCLES     = 300;
  localparam int PRESSURE_ITEMS  = 40;
  localparam int ONE_FRAME_ITEMS = 20;
  localparam int PHASE_ITEMS     = 118;
  localparam int NUM_PHASES      = 12;

  class frame_scoreboard;
    logic [7:0]         page_held [NUM_FRAMES];
    bit                 held      [NUM_FRAMES];
    logic [RANK_W-1:0]  age       [NUM_FRAMES];
    logic [FAULT_W-1:0] faults;
    logic [CFG_W-1:0]   frames_cfg;
    lrupfr_res_t        expected_lookups [$];
    int                 mismatches;

    function new();
      mismatches = 0;
      frames_cfg = CFG_RESET;
      clear_frames();
    endfunction

    function void clear_frames();
      for (int k = 0; k < NUM_FRAMES; k++) begin
        held[k] = 1'b0;
        age[k]  = '0;
      end
      faults = '0;
    endfunction

    function void set_frames(logic [CFG_W-1:0] v);
      frames_cfg = v;
    endfunction

    function int active_frames();
      if (frames_cfg == 0) return 1;
      if (frames_cfg > CFG_LIMIT) return NUM_FRAMES;
      return int'(frames_cfg);
    endfunction

    // most recent gets rank 0, younger valid frames age by one
    function void promote(int f);
      logic [RANK_W-1:0] old;
      old = age[f];
      for (int k = 0; k < NUM_FRAMES; k++) begin
        if (k != f && held[k] && age[k] < old) age[k] = age[k] + 1'b1;
      end
      age[f] = '0;
    endfunction

    function void note_reference(lrupfr_req_t r);
      int                n;
      int                f;
      bit                found;
      bit                empty;
      logic [7:0]        page;
      logic [RANK_W-1:0] oldest;
      lrupfr_res_t       e;
      n     = active_frames();
      f     = 0;
      found = 1'b0;
      empty = 1'b0;
      page  = r.page_number & PAGE_MASK;
      e     = '0;
      if (r.restart) clear_frames();
      for (int k = 0; k < n; k++) begin
        if (!found && held[k] && page_held[k] == page) begin
          f     = k;
          found = 1'b1;
        end
      end
      if (found) begin
        e.hit = 1'b1;
        promote(f);
      end else begin
        for (int k = 0; k < n; k++) begin
          if (!empty && !held[k]) begin
            f     = k;
            empty = 1'b1;
          end
        end
        if (empty) begin
          for (int k = 0; k < NUM_FRAMES; k++) begin
            if (held[k] && age[k] < RANK_OLDEST) age[k] = age[k] + 1'b1;
          end
          held[f] = 1'b1;
          age[f]  = '0;
        end else begin
          oldest = '0;
          f      = 0;
          for (int k = 0; k < n; k++) begin
            if (age[k] > oldest) begin
              oldest = age[k];
              f      = k;
            end
          end
          e.evicted_valid = 1'b1;
          e.evicted_page  = page_held[f];
          promote(f);
        end
        page_held[f] = page;
        if (faults != FAULT_MAX) faults = faults + 1'b1;
      end
      e.frame_index = 3'(f);
      e.fault_count = faults;
      expected_lookups.push_back(e);
    endfunction

    function void check_result(lrupfr_res_t got);
      lrupfr_res_t e;
      if (expected_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result hit=%0b frame=%0d ev=%0b evpage=%0h faults=%0d",
                   $realtime, got.hit, got.frame_index, got.evicted_valid,
                   got.evicted_page, got.fault_count);
        return;
      end
      e = expected_lookups.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("%0t: mismatch exp hit=%0b frame=%0d ev=%0b evpage=%0h faults=%0d",
                 $realtime, e.hit, e.frame_index, e.evicted_valid, e.evicted_page,
                 e.fault_count);
          $display(" got hit=%0b frame=%0d ev=%0b evpage=%0h faults=%0d",
                   got.hit, got.frame_index, got.evicted_valid,
                   got.evicted_page, got.fault_count);
        end
      end
    endfunction

    function int pending();
      return expected_lookups.size();
    endfunction
  endclass

  logic             clk;
  logic             rst        = 1'b1;
  logic             cfg_write  = 1'b0;
  logic [CFG_W-1:0] cfg_data   = '0;
  logic             in_valid   = 1'b0;
  logic             in_stall;
  lrupfr_req_t      in_req     = '0;
  logic             out_valid;
  logic             out_stall  = 1'b0;
  lrupfr_res_t      out_res;

  frame_scoreboard sb = new();

  bit tx_idle_on  = 1'b0;
  bit rx_idle_on  = 1'b0;
  int hold_id     = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int rx_wait     = 0;
  int rx_gap      = 0;
  int cycle_count = 0;
  int frame_plan [NUM_PHASES] = '{8, 1, 15, 0, 2, 9, 5, 8, 3, 7, 4, 6};

  lru_page_frame_replacer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: checks, per-result stall draw, long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_res);
      end
      if (hold_seen != hold_id) begin
        hold_seen <= hold_id;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= (hold_left > 1);
      end else if (rx_wait != 0) begin
        rx_wait   <= rx_wait - 1;
        out_stall <= (rx_wait > 1);
      end else if (out_valid && !out_stall && rx_idle_on) begin
        rx_gap     = $urandom_range(0, 16);
        rx_wait   <= rx_gap;
        out_stall <= (rx_gap != 0);
      end
    end
  end

  task automatic send_request(input logic [7:0] page, input logic restart);
    lrupfr_req_t req;
    int          gap;
    req.page_number = page;
    req.restart     = restart;
    gap = tx_idle_on ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    sb.note_reference(req);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] v);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_frames(v);
  endtask

  initial begin
    int         phase;
    int         pick;
    int         pool_size;
    logic [7:0] pool_base;
    logic [7:0] page;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_frames(CFG_RESET);
    send_request(8'h00, 1'b1);
    send_request(8'hFF, 1'b0);
    for (int p = 1; p <= 6; p++) send_request(8'(p), 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(8'h7F, 1'b0);
    send_request(8'h03, 1'b0);

    // page 5 sits outside the two active frames: miss, then held twice
    write_frames(4'd2);
    send_request(8'h05, 1'b0);
    send_request(8'h05, 1'b0);
    send_request(8'hAA, 1'b0);
    write_frames(4'd15);
    send_request(8'h05, 1'b0);
    write_frames(4'd0);
    send_request(8'h55, 1'b0);
    send_request(8'h55, 1'b0);
    send_request(8'hAA, 1'b1);

    // every reference misses with one frame
    write_frames(4'd1);
    for (int n = 0; n < ONE_FRAME_ITEMS; n++) send_request(8'(n), 1'b0);
    send_request(8'h01, 1'b1);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      write_frames(4'(frame_plan[phase]));
      tx_idle_on <= phase[0];
      rx_idle_on <= phase[1];
      pool_base = 8'($urandom);
      pool_size = frame_plan[phase] + $urandom_range(0, 4);
      if (pool_size < 2) pool_size = 2;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 39) pool_base = 8'($urandom);
        if (phase == 5 && i == 20) begin
          hold_id <= hold_id + 1;
          tx_idle_on <= 1'b0;
          for (int j = 0; j < PRESSURE_ITEMS; j++)
            send_request(pool_base + 8'($urandom_range(0, pool_size - 1)), 1'b0);
          tx_idle_on <= phase[0];
        end
        if (phase == 7 && i == 50) settle();
        pick = $urandom_range(0, 99);
        if (pick < 78) page = pool_base + 8'($urandom_range(0, pool_size - 1));
        else page = 8'($urandom);
        send_request(page, $urandom_range(0, 49) == 0);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
